FILE: rtl/lcd_nibble_write_sequencer_assert.svh
// ----------------------------------------------------------------------------
// lcd nibble write sequencer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LNWS_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lnws: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define LNWS_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lnws: next-cycle check failed");

`endif

FILE: rtl/lnws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnws_pkg
// types, constants and helpers for the lcd nibble write sequencer
// ----------------------------------------------------------------------------
package lnws_pkg;

    localparam int WAIT_COUNT_BITS = 20;
    localparam int PHASE_W         = 16;
    localparam int FIXED_W         = 20;
    localparam int CFG_DATA_W      = 20;
    localparam int CFG_ADDR_W      = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIXED_WAIT  = 1'd1;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd1;
    localparam logic [FIXED_W-1:0] FIXED_WAIT_RST  = 20'd10000;

    localparam logic [63:0] COUNT_CAP = (64'd1 << WAIT_COUNT_BITS) - 64'd1;

    typedef logic [WAIT_COUNT_BITS-1:0] count_t;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_POLL_HI     = 4'd1,
        PH_POLL_LO     = 4'd2,
        PH_POLL2_SETUP = 4'd3,
        PH_POLL2_HI    = 4'd4,
        PH_POLL2_HOLD  = 4'd5,
        PH_FIXED       = 4'd6,
        PH_UP_SETUP    = 4'd7,
        PH_UP_HI       = 4'd8,
        PH_UP_HOLD     = 4'd9,
        PH_LO_SETUP    = 4'd10,
        PH_LO_HI       = 4'd11,
        PH_LO_HOLD     = 4'd12
    } seq_phase_t;

    typedef struct packed {
        logic send_low;
        logic check_busy;
        logic is_data;
    } flags_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] cmd_byte;
        logic       is_data;
        logic       check_busy;
        logic       send_low;
        logic       busy_pin;
    } lnws_in_t;

    typedef struct packed {
        logic       rs_out;
        logic       rw_out;
        logic       e_out;
        logic [3:0] nibble_out;
        logic       bus_drive;
        logic       ready_res;
        logic       accepted;
        logic       write_done;
    } lnws_out_t;

    // zero acts as one tick, anything past the counter saturates
    function automatic count_t clamp_count(input logic [CFG_DATA_W-1:0] v);
        logic [63:0] w;
        w = {{(64-CFG_DATA_W){1'b0}}, v};
        if (w == 64'd0)
        begin
            w = 64'd1;
        end
        else if (w > COUNT_CAP)
        begin
            w = COUNT_CAP;
        end
        return w[WAIT_COUNT_BITS-1:0];
    endfunction

endpackage

FILE: rtl/lnws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnws channel interfaces
// valid/ready channels for tick items and pin results
// ----------------------------------------------------------------------------
interface lnws_in_if import lnws_pkg::*; ();
    logic     valid;
    logic     ready;
    lnws_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lnws_out_if import lnws_pkg::*; ();
    logic      valid;
    logic      ready;
    lnws_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nibble_write_sequencer
// pin sequencer for a character display on a 4-bit bus
// ----------------------------------------------------------------------------
// each transaction on in_ch is one time tick; it may carry a command request
// (byte plus data, poll-busy and send-low flags) and the busy level on d7.
// each tick yields exactly one transaction on out_ch with the rs, rw, e,
// d4..d7 and bus-drive levels after that tick, plus ready, accepted and
// write-done flags.
// the result of a tick sits in the output register in the cycle after its
// input transaction. throughput: one tick per cycle while out_ch is not
// stalled, with the single sequencer state update between input and result.
// when out_ch stalls, the result register holds and in_ch.ready drops, so no
// tick is lost; a new tick is taken in the same cycle the old result leaves.
// cfg_we writes phase_ticks (index 0) or fixed_wait_ticks (index 1); write
// only while no ticks are in flight.
// reset: sequencer idle, bus driven, pins low, phase_ticks 1,
// fixed_wait_ticks 10000, output register empty.
// ----------------------------------------------------------------------------
module lcd_nibble_write_sequencer import lnws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    lnws_in_if.sink               in_ch,
    lnws_out_if.source            out_ch
);

    logic [PHASE_W-1:0] phase_ticks_reg;
    logic [FIXED_W-1:0] fixed_wait_reg;

    seq_phase_t seq_phase_reg, seq_phase_next;
    count_t     count_reg, count_next;
    logic [7:0] byte_reg, byte_next;
    flags_t     flags_reg, flags_next;
    logic       seen_busy_reg, seen_busy_next;
    logic       rs_reg, rs_next;
    logic       rw_reg, rw_next;
    logic       e_reg, e_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       drive_reg, drive_next;

    logic       out_valid_reg, out_valid_next;
    lnws_out_t  out_data_reg, out_data_next;

    logic       in_fire;
    logic       acc;
    logic       done;
    logic       start_wr;
    count_t     phase_cnt;
    count_t     fixed_cnt;

    assign in_ch.ready    = !out_valid_reg || out_ch.ready;
    assign in_fire        = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_data_reg;

    assign phase_cnt = clamp_count({{(CFG_DATA_W-PHASE_W){1'b0}}, phase_ticks_reg});
    assign fixed_cnt = clamp_count(fixed_wait_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            fixed_wait_reg  <= FIXED_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PHASE_TICKS: phase_ticks_reg <= cfg_wdata[PHASE_W-1:0];
                REG_FIXED_WAIT:  fixed_wait_reg  <= cfg_wdata[FIXED_W-1:0];
                default:         phase_ticks_reg <= phase_ticks_reg;
            endcase
        end
    end

    // sequencer next state for one tick
    always_comb
    begin
        seq_phase_next = seq_phase_reg;
        count_next     = count_reg;
        byte_next      = byte_reg;
        flags_next     = flags_reg;
        seen_busy_next = seen_busy_reg;
        rs_next        = rs_reg;
        rw_next        = rw_reg;
        e_next         = e_reg;
        nibble_next    = nibble_reg;
        drive_next     = drive_reg;
        acc            = 1'b0;
        done           = 1'b0;
        start_wr       = 1'b0;

        if (seq_phase_reg == PH_IDLE)
        begin
            if (in_ch.payload.req_type)
            begin
                acc                   = 1'b1;
                byte_next             = in_ch.payload.cmd_byte;
                flags_next.is_data    = in_ch.payload.is_data;
                flags_next.check_busy = in_ch.payload.check_busy;
                flags_next.send_low   = in_ch.payload.send_low;
                seen_busy_next        = 1'b0;
                if (in_ch.payload.check_busy)
                begin
                    // release the bus and raise e for the first status read
                    rs_next        = 1'b0;
                    drive_next     = 1'b0;
                    rw_next        = 1'b1;
                    e_next         = 1'b1;
                    seq_phase_next = PH_POLL_HI;
                    count_next     = phase_cnt;
                end
                else
                begin
                    seq_phase_next = PH_FIXED;
                    count_next     = fixed_cnt;
                end
            end
        end
        else if (count_reg > count_t'(1))
        begin
            count_next = count_reg - count_t'(1);
        end
        else
        begin
            count_next = phase_cnt;
            unique case (seq_phase_reg)
                PH_POLL_HI:
                begin
                    seen_busy_next = in_ch.payload.busy_pin;
                    e_next         = 1'b0;
                    seq_phase_next = PH_POLL_LO;
                end
                PH_POLL_LO:
                begin
                    seq_phase_next = PH_POLL2_SETUP;
                end
                PH_POLL2_SETUP:
                begin
                    e_next         = 1'b1;
                    seq_phase_next = PH_POLL2_HI;
                end
                PH_POLL2_HI:
                begin
                    e_next         = 1'b0;
                    seq_phase_next = PH_POLL2_HOLD;
                end
                PH_POLL2_HOLD:
                begin
                    if (seen_busy_reg)
                    begin
                        e_next         = 1'b1;
                        seq_phase_next = PH_POLL_HI;
                    end
                    else
                    begin
                        start_wr = 1'b1;
                    end
                end
                PH_FIXED:
                begin
                    start_wr = 1'b1;
                end
                PH_UP_SETUP:
                begin
                    e_next         = 1'b1;
                    seq_phase_next = PH_UP_HI;
                end
                PH_LO_SETUP:
                begin
                    e_next         = 1'b1;
                    seq_phase_next = PH_LO_HI;
                end
                PH_UP_HI:
                begin
                    e_next         = 1'b0;
                    seq_phase_next = PH_UP_HOLD;
                end
                PH_LO_HI:
                begin
                    e_next         = 1'b0;
                    seq_phase_next = PH_LO_HOLD;
                end
                PH_UP_HOLD:
                begin
                    if (flags_reg.send_low)
                    begin
                        nibble_next    = byte_reg[3:0];
                        seq_phase_next = PH_LO_SETUP;
                    end
                    else
                    begin
                        seq_phase_next = PH_IDLE;
                        count_next     = '0;
                        done           = 1'b1;
                    end
                end
                PH_LO_HOLD:
                begin
                    seq_phase_next = PH_IDLE;
                    count_next     = '0;
                    done           = 1'b1;
                end
                default:
                begin
                    seq_phase_next = PH_IDLE;
                    count_next     = '0;
                end
            endcase
        end

        // drive the bus with the upper nibble and start its setup phase
        if (start_wr)
        begin
            rw_next        = 1'b0;
            drive_next     = 1'b1;
            rs_next        = flags_reg.is_data;
            nibble_next    = byte_reg[7:4];
            seq_phase_next = PH_UP_SETUP;
            count_next     = phase_cnt;
        end
    end

    always_comb
    begin
        out_data_next.rs_out     = rs_next;
        out_data_next.rw_out     = rw_next;
        out_data_next.e_out      = e_next;
        out_data_next.nibble_out = nibble_next;
        out_data_next.bus_drive  = drive_next;
        out_data_next.ready_res  = (seq_phase_next == PH_IDLE);
        out_data_next.accepted   = acc;
        out_data_next.write_done = done;

        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_phase_reg <= PH_IDLE;
            count_reg     <= '0;
            byte_reg      <= '0;
            flags_reg     <= '0;
            seen_busy_reg <= 1'b0;
            rs_reg        <= 1'b0;
            rw_reg        <= 1'b0;
            e_reg         <= 1'b0;
            nibble_reg    <= '0;
            drive_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                seq_phase_reg <= seq_phase_next;
                count_reg     <= count_next;
                byte_reg      <= byte_next;
                flags_reg     <= flags_next;
                seen_busy_reg <= seen_busy_next;
                rs_reg        <= rs_next;
                rw_reg        <= rw_next;
                e_reg         <= e_next;
                nibble_reg    <= nibble_next;
                drive_reg     <= drive_next;
            end
        end
    end

    // result register, payload only
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: rtl/lnws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnws_checker
// port-level checks for the lcd nibble write sequencer
// ----------------------------------------------------------------------------
`include "lcd_nibble_write_sequencer_assert.svh"

module lnws_checker import lnws_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input lnws_out_t out_data
);

    // a stalled result stays put
    `LNWS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // an empty result register never blocks a tick
    `LNWS_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

    // every tick yields a result in the next cycle
    `LNWS_ASSERT_NXT(a_tick_gives_result, in_valid && in_ready, out_valid)

    // a taken command always leaves the sequencer busy
    `LNWS_ASSERT_IMP(a_accept_busy, out_valid && out_data.accepted, !out_data.ready_res)

    // a finished write ends idle with e low
    `LNWS_ASSERT_IMP(a_done_idle, out_valid && out_data.write_done,
        out_data.ready_res && !out_data.e_out)

endmodule

bind lcd_nibble_write_sequencer lnws_checker u_lnws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.payload)
);

FILE: tb/sv/tb_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_nibble_write_sequencer
// self-checking bench for the character display pin sequencer
// ----------------------------------------------------------------------------
// every input tick is mirrored into a local pin model, which queues the pin
// levels and flags it expects; the output monitor pops and compares each
// result field by field. directed writes cover all flag mixes, busy polling
// loops, zero and longer counts and register masking; random traffic
// runs under several idle and stall mixes, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_lcd_nibble_write_sequencer;
    import lnws_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned PRINT_CAP   = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lnws_in_if  in_ch ();
    lnws_out_if out_ch ();

    lcd_nibble_write_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // pin model state
    seq_phase_t     sq_phase;
    count_t         sq_count;
    logic [7:0]     sq_byte;
    flags_t         sq_flags;
    logic           sq_seen_busy;
    logic           p_rs;
    logic           p_rw;
    logic           p_e;
    logic [3:0]     p_nib;
    logic           p_drive;
    logic [19:0]    set_phase_ticks;
    logic [19:0]    set_fixed_wait;

    lnws_out_t      pins_expected[$];

    int unsigned    tx_idle_pct;
    int unsigned    rx_stall_pct;
    int unsigned    busy_pct;
    int unsigned    rx_hold_left;
    int unsigned    cycle_count;
    int unsigned    mismatch_count;
    int unsigned    results_checked;
    int unsigned    cmds_taken;
    int unsigned    cmds_polled;
    int unsigned    writes_finished;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_lcd_nibble_write_sequencer: done, errors");
            $finish;
        end
    end

    // long output hold-off, armed from the test sequence at a falling edge
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("mismatch %s: got %0h expected %0h (result %0d, cycle %0d)",
                     what, got, exp, results_checked, cycle_count);
        end
    endtask

    task automatic check_pins(input lnws_out_t got);
        lnws_out_t exp;
        if (pins_expected.size() == 0)
        begin
            note_mismatch("unexpected result", 32'(got), 0);
            return;
        end
        exp = pins_expected.pop_front();
        results_checked++;
        if (got.rs_out !== exp.rs_out)
            note_mismatch("rs_out", 32'(got.rs_out), 32'(exp.rs_out));
        if (got.rw_out !== exp.rw_out)
            note_mismatch("rw_out", 32'(got.rw_out), 32'(exp.rw_out));
        if (got.e_out !== exp.e_out)
            note_mismatch("e_out", 32'(got.e_out), 32'(exp.e_out));
        if (got.nibble_out !== exp.nibble_out)
            note_mismatch("nibble_out", 32'(got.nibble_out), 32'(exp.nibble_out));
        if (got.bus_drive !== exp.bus_drive)
            note_mismatch("bus_drive", 32'(got.bus_drive), 32'(exp.bus_drive));
        if (got.ready_res !== exp.ready_res)
            note_mismatch("ready_res", 32'(got.ready_res), 32'(exp.ready_res));
        if (got.accepted !== exp.accepted)
            note_mismatch("accepted", 32'(got.accepted), 32'(exp.accepted));
        if (got.write_done !== exp.write_done)
            note_mismatch("write_done", 32'(got.write_done), 32'(exp.write_done));
    endtask

    // output monitor and sink
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                check_pins(out_ch.payload);
            end
            out_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // pin model
    // ------------------------------------------------------------------------
    function automatic void enter_phase(input seq_phase_t ph, input logic [19:0] n);
        sq_phase = ph;
        sq_count = (n == 20'd0) ? count_t'(1) : count_t'(n);
    endfunction

    function automatic void load_upper_nibble();
        p_rw    = 1'b0;
        p_drive = 1'b1;
        p_rs    = sq_flags.is_data;
        p_nib   = sq_byte[7:4];
        enter_phase(PH_UP_SETUP, set_phase_ticks);
    endfunction

    // what happens when the running phase has used up its count
    function automatic logic close_phase(input logic busy);
        logic fin;
        fin = 1'b0;
        case (sq_phase)
            PH_POLL_HI:
            begin
                sq_seen_busy = busy;
                p_e = 1'b0;
                enter_phase(PH_POLL_LO, set_phase_ticks);
            end
            PH_POLL_LO:
            begin
                enter_phase(PH_POLL2_SETUP, set_phase_ticks);
            end
            PH_POLL2_SETUP:
            begin
                p_e = 1'b1;
                enter_phase(PH_POLL2_HI, set_phase_ticks);
            end
            PH_POLL2_HI:
            begin
                p_e = 1'b0;
                enter_phase(PH_POLL2_HOLD, set_phase_ticks);
            end
            PH_POLL2_HOLD:
            begin
                if (sq_seen_busy)
                begin
                    p_e = 1'b1;
                    enter_phase(PH_POLL_HI, set_phase_ticks);
                end
                else
                begin
                    load_upper_nibble();
                end
            end
            PH_FIXED:
            begin
                load_upper_nibble();
            end
            PH_UP_SETUP:
            begin
                p_e = 1'b1;
                enter_phase(PH_UP_HI, set_phase_ticks);
            end
            PH_LO_SETUP:
            begin
                p_e = 1'b1;
                enter_phase(PH_LO_HI, set_phase_ticks);
            end
            PH_UP_HI:
            begin
                p_e = 1'b0;
                enter_phase(PH_UP_HOLD, set_phase_ticks);
            end
            PH_LO_HI:
            begin
                p_e = 1'b0;
                enter_phase(PH_LO_HOLD, set_phase_ticks);
            end
            PH_UP_HOLD:
            begin
                if (sq_flags.send_low)
                begin
                    p_nib = sq_byte[3:0];
                    enter_phase(PH_LO_SETUP, set_phase_ticks);
                end
                else
                begin
                    sq_phase = PH_IDLE;
                    sq_count = '0;
                    fin      = 1'b1;
                end
            end
            PH_LO_HOLD:
            begin
                sq_phase = PH_IDLE;
                sq_count = '0;
                fin      = 1'b1;
            end
            default:
            begin
                sq_phase = PH_IDLE;
                sq_count = '0;
            end
        endcase
        return fin;
    endfunction

    function automatic lnws_out_t step_pins(input lnws_in_t t);
        lnws_out_t r;
        logic      took;
        logic      fin;
        took = 1'b0;
        fin  = 1'b0;
        if (sq_phase == PH_IDLE)
        begin
            if (t.req_type)
            begin
                took                = 1'b1;
                sq_byte             = t.cmd_byte;
                sq_flags.is_data    = t.is_data;
                sq_flags.check_busy = t.check_busy;
                sq_flags.send_low   = t.send_low;
                sq_seen_busy        = 1'b0;
                cmds_taken++;
                if (t.check_busy)
                begin
                    // bus released and e raised on the accepting tick
                    p_rs    = 1'b0;
                    p_drive = 1'b0;
                    p_rw    = 1'b1;
                    p_e     = 1'b1;
                    cmds_polled++;
                    enter_phase(PH_POLL_HI, set_phase_ticks);
                end
                else
                begin
                    enter_phase(PH_FIXED, set_fixed_wait);
                end
            end
        end
        else if (sq_count > 1)
        begin
            sq_count = sq_count - count_t'(1);
        end
        else
        begin
            fin = close_phase(t.busy_pin);
        end
        if (fin)
        begin
            writes_finished++;
        end
        r.rs_out     = p_rs;
        r.rw_out     = p_rw;
        r.e_out      = p_e;
        r.nibble_out = p_nib;
        r.bus_drive  = p_drive;
        r.ready_res  = (sq_phase == PH_IDLE);
        r.accepted   = took;
        r.write_done = fin;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic lnws_in_t random_item();
        logic [31:0] raw;
        lnws_in_t    t;
        raw        = $urandom;
        t          = raw[$bits(lnws_in_t)-1:0];
        t.busy_pin = ($urandom_range(99) < busy_pct);
        return t;
    endfunction

    // called at a rising edge; returns at the edge the transaction is taken
    task automatic send_tick(input lnws_in_t t);
        int unsigned gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct && gap < 40)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= t;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        pins_expected.push_back(step_pins(t));
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (pins_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_PHASE_TICKS)
        begin
            set_phase_ticks = {4'd0, v[15:0]};
        end
        else
        begin
            set_fixed_wait = v;
        end
    endtask

    // plain ticks until the sequencer is idle; d7 reads busy on the first
    // busy_reads samples, stray requests land while busy and are dropped
    task automatic finish_write(input int unsigned busy_reads);
        lnws_in_t    t;
        int unsigned reads;
        reads = 0;
        while (sq_phase != PH_IDLE)
        begin
            t          = random_item();
            t.req_type = ($urandom_range(3) == 0);
            t.busy_pin = (reads < busy_reads);
            if (sq_phase == PH_POLL_HI && sq_count <= 1)
            begin
                reads++;
            end
            send_tick(t);
        end
    endtask

    task automatic write_cmd(input logic [7:0] b, input logic data, input logic poll,
                             input logic low, input int unsigned busy_reads);
        lnws_in_t t;
        finish_write(0);
        t            = random_item();
        t.req_type   = 1'b1;
        t.cmd_byte   = b;
        t.is_data    = data;
        t.check_busy = poll;
        t.send_low   = low;
        send_tick(t);
        finish_write(busy_reads);
    endtask

    task automatic random_ticks(input int unsigned n);
        lnws_in_t t;
        repeat (n)
        begin
            t = random_item();
            if (sq_phase == PH_IDLE)
            begin
                t.req_type = ($urandom_range(99) < 75);
            end
            else
            begin
                t.req_type = ($urandom_range(99) < 8);
            end
            send_tick(t);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_config();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_cmd(8'h0C, 1'b0, 1'b1, 1'b1, 1);
        wait_results_drained();
    endtask

    task automatic test_directed_writes();
        // zero counts act as a single tick
        write_reg(REG_PHASE_TICKS, 20'd0);
        write_reg(REG_FIXED_WAIT, 20'd0);
        write_cmd(8'h00, 1'b0, 1'b0, 1'b0, 0);
        write_cmd(8'hFF, 1'b1, 1'b0, 1'b1, 0);
        write_cmd(8'hA5, 1'b0, 1'b1, 1'b1, 0);
        write_cmd(8'h5A, 1'b1, 1'b1, 1'b0, 2);
        write_cmd(8'h3C, 1'b1, 1'b1, 1'b1, 1);
        write_cmd(8'hC3, 1'b0, 1'b0, 1'b1, 0);
        write_cmd(8'h0F, 1'b0, 1'b1, 1'b0, 0);
        wait_results_drained();
        // upper data bits beyond the phase register are dropped
        write_reg(REG_PHASE_TICKS, 20'hF0002);
        write_reg(REG_FIXED_WAIT, 20'd3);
        write_cmd(8'h81, 1'b1, 1'b1, 1'b1, 1);
        write_cmd(8'h7E, 1'b0, 1'b0, 1'b0, 0);
        write_cmd(8'hF0, 1'b1, 1'b0, 1'b1, 0);
        wait_results_drained();
    endtask

    task automatic test_long_counts();
        write_reg(REG_PHASE_TICKS, 20'd40);
        write_reg(REG_FIXED_WAIT, 20'd1);
        write_cmd(8'h96, 1'b1, 1'b0, 1'b0, 0);
        wait_results_drained();
        write_reg(REG_PHASE_TICKS, 20'd1);
        write_reg(REG_FIXED_WAIT, 20'd150);
        write_cmd(8'h69, 1'b0, 1'b1, 1'b1, 3);
        write_cmd(8'hB4, 1'b1, 1'b0, 1'b1, 0);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned tx_mix[4];
        int unsigned rx_mix[4];
        tx_mix = '{0, 70, 0, 21};
        rx_mix = '{0, 0, 70, 21};
        busy_pct = 30;
        for (int m = 0; m < 4; m++)
        begin
            wait_results_drained();
            write_reg(REG_PHASE_TICKS, {4'($urandom), 16'($urandom_range(3))});
            write_reg(REG_FIXED_WAIT, 20'($urandom_range(8)));
            tx_idle_pct  = tx_mix[m];
            rx_stall_pct = rx_mix[m];
            random_ticks(250);
        end
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_reg(REG_PHASE_TICKS, 20'd2);
        write_reg(REG_FIXED_WAIT, 20'd2);
        @(negedge clk);
        rx_hold_left = 150;
        @(posedge clk);
        // sender keeps offering while the sink is held off
        random_ticks(60);
        wait_results_drained();
        random_ticks(40);
        wait_results_drained();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.payload   = '0;
        out_ch.ready    = 1'b0;
        cycle_count     = 0;
        mismatch_count  = 0;
        results_checked = 0;
        cmds_taken      = 0;
        cmds_polled     = 0;
        writes_finished = 0;
        rx_hold_left    = 0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        busy_pct        = 30;
        sq_phase        = PH_IDLE;
        sq_count        = '0;
        sq_byte         = '0;
        sq_flags        = '0;
        sq_seen_busy    = 1'b0;
        p_rs            = 1'b0;
        p_rw            = 1'b0;
        p_e             = 1'b0;
        p_nib           = '0;
        p_drive         = 1'b1;
        set_phase_ticks = {4'd0, PHASE_TICKS_RST};
        set_fixed_wait  = FIXED_WAIT_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_directed_writes();
        test_long_counts();
        test_random_traffic();
        test_output_backpressure();

        wait_results_drained();
        repeat (4) @(posedge clk);
        $display("covered %0d commands (%0d with busy polling), %0d finished writes",
                 cmds_taken, cmds_polled, writes_finished);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 results_checked, cycle_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("tb_lcd_nibble_write_sequencer: done, clean");
        end
        else
        begin
            $display("tb_lcd_nibble_write_sequencer: done, errors");
        end
        $finish;
    end

endmodule
